// ===== sv/bfea_pkg.sv =====
// ----------------------------------------------------------------------------
// bfea_pkg
// Shared types and constants of the best-fit extent allocator.
// ----------------------------------------------------------------------------
package bfea_pkg;

    localparam int MAX_EXTENTS_DEF   = 64;
    localparam int MAX_PAGES_DEF     = 16384;

    localparam int PID_W             = 16;
    localparam int NPAGES_W          = 15;
    localparam int STATUS_W          = 2;
    localparam int START_W           = 14;
    localparam int PCOUNT_W          = 7;

    localparam logic [NPAGES_W-1:0] INIT_PAGES_RESET = 15'd256;
    localparam logic [PCOUNT_W-1:0] COUNT_LIMIT      = 7'd127;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK          = 2'd0,
        STAT_NO_SPACE    = 2'd1,
        STAT_BAD_REQ     = 2'd2,
        STAT_NONE_FREED  = 2'd3
    } t_status;

endpackage

// ===== sv/best_fit_extent_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// best_fit_extent_allocator_unit
// Best-fit page-extent allocator with coalescing of free neighbors.
// ----------------------------------------------------------------------------
// The extent table sits in one RAM with a registered read, scanned one entry
// per cycle. An allocate runs a best-fit scan over the table, then, when the
// chosen extent is split, shifts each entry above it up by one to insert the
// free remainder. A free compacts and merges the table in a single pass. A bad
// request goes straight to the result. busy is high while a request is in
// flight; the result appears for exactly one cycle with o_done and cannot be
// stalled. A configuration write (taken only when idle) reinitializes the
// table and raises busy while it does so, as does the table setup after reset.
module best_fit_extent_allocator_unit
    import bfea_pkg::*;
#(
    parameter int MAX_EXTENTS = MAX_EXTENTS_DEF,
    parameter int MAX_PAGES   = MAX_PAGES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_req_type,
    input  logic [PID_W-1:0]    i_pid,
    input  logic [NPAGES_W-1:0] i_num_pages,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [NPAGES_W-1:0] i_cfg_initial_pages,
    output logic                o_done,
    output logic [STATUS_W-1:0] o_status,
    output logic [START_W-1:0]  o_start_page,
    output logic [NPAGES_W-1:0] o_freed_pages,
    output logic [NPAGES_W-1:0] o_free_cnt,
    output logic [NPAGES_W-1:0] o_used_cnt,
    output logic [NPAGES_W-1:0] o_store_size,
    output logic [PCOUNT_W-1:0] o_process_count
);

    localparam int PW = $clog2(MAX_PAGES + 1);
    localparam int IW = $clog2(MAX_EXTENTS);
    localparam int CW = $clog2(MAX_EXTENTS + 1);
    localparam int EW = 2 * PW + PID_W;
    localparam int SW = ((PW > NPAGES_W) ? PW : NPAGES_W) + 2;

    typedef struct packed {
        logic [PW-1:0]    start;
        logic [PW-1:0]    pages;
        logic [PID_W-1:0] pid;
    } t_extent;

    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_SCAN, S_GROW, S_PREP, S_SHIFT,
        S_WRITE1, S_WRITE2, S_FREE, S_FLUSH, S_DONE
    } t_state;

    t_state               r_state;
    logic [NPAGES_W-1:0]  r_init;
    logic [PID_W-1:0]     r_pid;
    logic [NPAGES_W-1:0]  r_n;
    logic [CW-1:0]        r_count;
    logic [PW-1:0]        r_store;
    logic [PW-1:0]        r_alloc;
    logic [PCOUNT_W-1:0]  r_live;
    logic [CW-1:0]        r_ptr;
    logic                 r_rd_vld;
    logic [IW-1:0]        r_rd_addr;
    logic                 r_found;
    logic                 r_stop;
    logic [IW-1:0]        r_best;
    logic [PW-1:0]        r_best_pages;
    logic [PW-1:0]        r_best_start;
    logic [CW-1:0]        r_w;
    t_extent              r_hold;
    logic                 r_hold_vld;
    logic [PW-1:0]        r_sum;
    t_status              r_status;
    logic [PW-1:0]        r_start_out;

    logic                 r_o_done;
    logic [STATUS_W-1:0]  r_o_status;
    logic [START_W-1:0]   r_o_start;
    logic [NPAGES_W-1:0]  r_o_freed;
    logic [NPAGES_W-1:0]  r_o_free;
    logic [NPAGES_W-1:0]  r_o_used;
    logic [NPAGES_W-1:0]  r_o_total;
    logic [PCOUNT_W-1:0]  r_o_pcount;

    logic                 ram_we;
    logic [IW-1:0]        ram_waddr;
    logic [EW-1:0]        ram_wdata;
    logic                 ram_re;
    logic [IW-1:0]        ram_raddr;
    logic [EW-1:0]        ram_rdata;

    t_extent              rd_ext;
    t_extent              cur_ext;
    t_extent              w_ext;
    logic                 cur_mine;
    logic                 merge;
    logic                 split;
    logic [PW-1:0]        init_n;
    logic [PW-1:0]        w1_pages;
    logic [SW-1:0]        grow_add;
    logic [SW-1:0]        alloc_sum;
    logic                 cand;
    logic                 cfg_acc;
    logic                 req_acc;

    bfea_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_EXTENTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign busy        = (r_state != S_IDLE);
    assign req_acc     = start && !busy;
    assign o_cfg_ready = (r_state == S_IDLE) && !start;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;

    assign init_n = (SW'(r_init) > SW'(MAX_PAGES)) ? PW'(MAX_PAGES) : PW'(r_init);

    always_comb begin
        rd_ext   = t_extent'(ram_rdata);
        cur_mine = (rd_ext.pid == r_pid);
        cur_ext  = rd_ext;
        if (cur_mine) begin
            cur_ext.pid = '0;
        end
        merge = r_hold_vld && (r_hold.pid == '0) && (cur_ext.pid == '0);
        cand  = (rd_ext.pid == '0) && (SW'(rd_ext.pages) >= SW'(r_n))
                && (!r_found || (rd_ext.pages < r_best_pages));
        split = (SW'(r_best_pages) > SW'(r_n)) && (r_count < CW'(MAX_EXTENTS));
        w1_pages  = split ? PW'(r_n) : r_best_pages;
        grow_add  = SW'(r_n) + (SW'(r_n) >> 1);
        alloc_sum = SW'(r_alloc) + SW'(w1_pages);

        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_re    = 1'b0;
        ram_raddr = r_ptr[IW-1:0];
        w_ext     = r_hold;
        case (r_state)
            S_INIT: begin
                ram_we      = 1'b1;
                w_ext.start = '0;
                w_ext.pages = init_n;
                w_ext.pid   = '0;
            end
            S_SCAN: begin
                ram_re = (r_ptr < r_count) && !r_stop;
            end
            S_SHIFT: begin
                ram_re    = (r_ptr != CW'(r_best));
                ram_we    = r_rd_vld;
                ram_waddr = IW'(r_rd_addr + 1'b1);
                w_ext     = rd_ext;
            end
            S_WRITE1: begin
                ram_we      = 1'b1;
                ram_waddr   = r_best;
                w_ext.start = r_best_start;
                w_ext.pages = w1_pages;
                w_ext.pid   = r_pid;
            end
            S_WRITE2: begin
                ram_we      = 1'b1;
                ram_waddr   = IW'(r_best + 1'b1);
                w_ext.start = r_best_start + PW'(r_n);
                w_ext.pages = r_best_pages - PW'(r_n);
                w_ext.pid   = '0;
            end
            S_FREE: begin
                ram_re    = (r_ptr < r_count);
                ram_we    = r_rd_vld && !merge && r_hold_vld;
                ram_waddr = r_w[IW-1:0];
            end
            S_FLUSH: begin
                ram_we    = r_hold_vld;
                ram_waddr = r_w[IW-1:0];
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
        ram_wdata = w_ext;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_init   <= INIT_PAGES_RESET;
            r_count  <= '0;
            r_store  <= '0;
            r_alloc  <= '0;
            r_live   <= '0;
            r_rd_vld <= 1'b0;
            r_o_done <= 1'b0;
        end else begin
            r_rd_vld  <= ram_re;
            r_rd_addr <= ram_raddr;
            r_o_done  <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (req_acc) begin
                        r_pid       <= i_pid;
                        r_n         <= i_num_pages;
                        r_ptr       <= '0;
                        r_found     <= 1'b0;
                        r_stop      <= 1'b0;
                        r_w         <= '0;
                        r_hold_vld  <= 1'b0;
                        r_sum       <= '0;
                        r_start_out <= '0;
                        if (i_pid == '0 || (i_req_type == REQ_ALLOC && i_num_pages == '0)) begin
                            r_status <= STAT_BAD_REQ;
                            r_state  <= S_DONE;
                        end else if (i_req_type == REQ_ALLOC) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_FREE;
                        end
                    end else if (cfg_acc) begin
                        r_init  <= i_cfg_initial_pages;
                        r_state <= S_INIT;
                    end
                end
                S_INIT: begin
                    r_count <= (init_n != '0) ? CW'(1) : '0;
                    r_store <= init_n;
                    r_alloc <= '0;
                    r_live  <= '0;
                    r_state <= S_IDLE;
                end
                S_SCAN: begin
                    if (ram_re) begin
                        r_ptr <= r_ptr + 1'b1;
                    end
                    if (r_rd_vld && !r_stop && cand) begin
                        r_best       <= r_rd_addr;
                        r_best_pages <= rd_ext.pages;
                        r_best_start <= rd_ext.start;
                        r_found      <= 1'b1;
                        if (SW'(rd_ext.pages) == SW'(r_n)) begin
                            r_stop <= 1'b1;
                        end
                    end
                    if (!ram_re && !r_rd_vld) begin
                        r_state <= S_GROW;
                    end
                end
                S_GROW: begin
                    if (r_found) begin
                        r_state <= S_PREP;
                    end else if ((SW'(r_store) + grow_add > SW'(MAX_PAGES))
                                 || (r_count >= CW'(MAX_EXTENTS))) begin
                        r_status <= STAT_NO_SPACE;
                        r_state  <= S_DONE;
                    end else begin
                        // new free tail extent becomes the chosen one
                        r_best       <= r_count[IW-1:0];
                        r_best_pages <= PW'(grow_add);
                        r_best_start <= r_store;
                        r_store      <= PW'(SW'(r_store) + grow_add);
                        r_count      <= r_count + 1'b1;
                        r_state      <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_ptr   <= CW'(r_count - 1'b1);
                    r_state <= split ? S_SHIFT : S_WRITE1;
                end
                S_SHIFT: begin
                    if (ram_re) begin
                        r_ptr <= r_ptr - 1'b1;
                    end
                    if (!ram_re && !r_rd_vld) begin
                        r_state <= S_WRITE1;
                    end
                end
                S_WRITE1: begin
                    r_alloc     <= (alloc_sum > SW'(MAX_PAGES)) ? PW'(MAX_PAGES)
                                                                : PW'(alloc_sum);
                    if (r_live < COUNT_LIMIT) begin
                        r_live <= r_live + 1'b1;
                    end
                    r_start_out <= r_best_start;
                    r_status    <= STAT_OK;
                    r_state     <= split ? S_WRITE2 : S_DONE;
                end
                S_WRITE2: begin
                    r_count <= r_count + 1'b1;
                    r_state <= S_DONE;
                end
                S_FREE: begin
                    if (ram_re) begin
                        r_ptr <= r_ptr + 1'b1;
                    end
                    if (r_rd_vld) begin
                        if (cur_mine) begin
                            r_sum <= r_sum + rd_ext.pages;
                        end
                        if (merge) begin
                            r_hold.pages <= r_hold.pages + cur_ext.pages;
                        end else begin
                            r_hold     <= cur_ext;
                            r_hold_vld <= 1'b1;
                            if (r_hold_vld) begin
                                r_w <= r_w + 1'b1;
                            end
                        end
                    end
                    if (!ram_re && !r_rd_vld) begin
                        r_state <= S_FLUSH;
                    end
                end
                S_FLUSH: begin
                    r_count <= r_hold_vld ? r_w + 1'b1 : r_w;
                    if (r_sum == '0) begin
                        r_status <= STAT_NONE_FREED;
                    end else begin
                        r_status <= STAT_OK;
                        r_alloc  <= (r_alloc > r_sum) ? r_alloc - r_sum : '0;
                        if (r_live != '0) begin
                            r_live <= r_live - 1'b1;
                        end
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_o_done   <= 1'b1;
                    r_o_status <= r_status;
                    r_o_start  <= START_W'(r_start_out);
                    r_o_freed  <= NPAGES_W'(r_sum);
                    r_o_free   <= NPAGES_W'(r_store - r_alloc);
                    r_o_used   <= NPAGES_W'(r_alloc);
                    r_o_total  <= NPAGES_W'(r_store);
                    r_o_pcount <= r_live;
                    r_state    <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done          = r_o_done;
    assign o_status        = r_o_status;
    assign o_start_page    = r_o_start;
    assign o_freed_pages   = r_o_freed;
    assign o_free_cnt      = r_o_free;
    assign o_used_cnt      = r_o_used;
    assign o_store_size    = r_o_total;
    assign o_process_count = r_o_pcount;

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held longer than one cycle");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_EXTENTS))
        else $error("extent count beyond table depth");

    a_used_le_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_alloc <= r_store)
        else $error("allocated pages exceed store size");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

endmodule

// ===== sv/bfea_ram.sv =====
// ----------------------------------------------------------------------------
// bfea_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bfea_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
